// ===== sv/mtb_pkg.sv =====
package mtb_pkg;

  localparam int NUM_TIMERS = 4;
  localparam int IDX_W      = 2;
  localparam int WALK_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TIME_W     = 32;
  localparam int STEP_W     = 16;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_QUIET  = 2'd3;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_PENDING = 2'd1,
    ST_STOPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic              load;
    logic              tick;
    logic              step;
    logic              emit;
    logic [WALK_W-1:0] walk_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic fire_now;
    logic none_pending;
  } ctrl_sts_t;

endpackage

// ===== sv/mtb_ifs.sv =====
interface mtb_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [mtb_pkg::IDX_W-1:0]  timer_index;
  logic                       periodic;
  logic [mtb_pkg::TIME_W-1:0] delay;
  logic [31:0]                user_tag;

  modport source (output valid, command, timer_index, periodic, delay, user_tag,
                  input ready);
  modport sink (input valid, command, timer_index, periodic, delay, user_tag,
                output ready);
endinterface

interface mtb_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [mtb_pkg::IDX_W-1:0] fired_index;
  logic [31:0]               fired_tag;
  logic                      last;

  modport source (output valid, kind, fired_index, fired_tag, last, input ready);
  modport sink (input valid, kind, fired_index, fired_tag, last, output ready);
endinterface

// ===== sv/mtb_ctrl.sv =====
module mtb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_is_tick,
  output logic               in_ready,
  input  mtb_pkg::ctrl_sts_t sts,
  output mtb_pkg::ctrl_cmd_t cmd
);
  import mtb_pkg::*;

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t            state;
  logic [WALK_W-1:0] walk;
  logic              accept;
  logic              walk_last;
  logic              need_emit;
  logic              advance;

  assign walk_last = (walk == WALK_W'(NUM_TIMERS - 1));
  assign need_emit = sts.fire_now || (walk_last && sts.none_pending);
  assign advance   = (state == S_WALK) && (!need_emit || sts.can_emit);
  assign in_ready  = (state == S_IDLE) && sts.can_emit;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.load     = accept && !in_is_tick;
    cmd.tick     = accept && in_is_tick;
    cmd.step     = advance;
    cmd.emit     = advance && need_emit;
    cmd.walk_idx = walk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      walk  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && in_is_tick) begin
            state <= S_WALK;
            walk  <= '0;
          end
        end
        S_WALK: begin
          if (advance) begin
            if (walk_last) begin
              state <= S_IDLE;
            end else begin
              walk <= walk + WALK_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/mtb_datapath.sv =====
module mtb_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [mtb_pkg::STEP_W-1:0]  cfg_data,
  input  logic [1:0]                  command,
  input  logic [mtb_pkg::IDX_W-1:0]   timer_index,
  input  logic                        periodic,
  input  logic [mtb_pkg::TIME_W-1:0]  delay,
  input  logic [31:0]                 user_tag,
  input  mtb_pkg::ctrl_cmd_t          cmd,
  output mtb_pkg::ctrl_sts_t          sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [mtb_pkg::IDX_W-1:0]   out_index,
  output logic [31:0]                 out_tag,
  output logic                        out_last
);
  import mtb_pkg::*;

  logic [STEP_W-1:0] tick_step;
  logic [TIME_W-1:0] now_time;
  status_t           timer_status  [NUM_TIMERS];
  logic              timer_mode    [NUM_TIMERS];
  logic [TIME_W-1:0] deadline      [NUM_TIMERS];
  logic [TIME_W-1:0] reload_period [NUM_TIMERS];
  logic [31:0]       stored_tag    [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] pend_mask;
  logic [NUM_TIMERS-1:0] snap_mask;

  logic              bad_id;
  logic              start_ok;
  logic              stop_ok;
  logic [WALK_W-1:0] sel;
  logic [WALK_W-1:0] w;
  logic              later_fire;

  assign w        = cmd.walk_idx;
  assign sel      = WALK_W'(timer_index);
  assign bad_id   = (32'(timer_index) >= 32'(NUM_TIMERS));
  assign start_ok = (command == CMD_START) && !bad_id && (delay != '0);
  assign stop_ok  = (command == CMD_STOP) && !bad_id;

  always_comb begin
    for (int j = 0; j < NUM_TIMERS; j++) begin
      snap_mask[j] = (timer_status[j] == ST_PENDING);
    end
  end

  // any fire still to come after the current entry
  always_comb begin
    later_fire = 1'b0;
    for (int j = 0; j < NUM_TIMERS; j++) begin
      if ((32'(j) > 32'(w)) && pend_mask[j]) begin
        later_fire = 1'b1;
      end
    end
  end

  always_comb begin
    sts.can_emit     = !out_valid || out_ready;
    sts.fire_now     = (timer_status[w] == ST_PENDING);
    sts.none_pending = (pend_mask == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= STEP_RESET;
      now_time  <= '0;
      pend_mask <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < NUM_TIMERS; j++) begin
        timer_status[j] <= ST_STOPPED;
        timer_mode[j]   <= 1'b0;
        deadline[j]     <= '0;
      end
    end else begin
      if (cfg_write) begin
        tick_step <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
        if (start_ok) begin
          deadline[sel]     <= now_time + delay;
          timer_mode[sel]   <= periodic;
          timer_status[sel] <= ST_RUNNING;
        end else if (stop_ok) begin
          timer_status[sel] <= ST_STOPPED;
        end
      end
      if (cmd.tick) begin
        now_time  <= now_time + TIME_W'(tick_step);
        pend_mask <= snap_mask;
      end
      if (cmd.step) begin
        unique case (timer_status[w])
          ST_RUNNING: begin
            if (deadline[w] < now_time) begin
              timer_status[w] <= ST_PENDING;
            end
          end
          ST_PENDING: begin
            if (timer_mode[w]) begin
              deadline[w]     <= now_time + reload_period[w];
              timer_status[w] <= ST_RUNNING;
            end else begin
              timer_status[w] <= ST_STOPPED;
            end
          end
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (cmd.load && start_ok) begin
      reload_period[sel] <= delay;
      stored_tag[sel]    <= user_tag;
    end
    if (cmd.load) begin
      out_kind  <= (start_ok || stop_ok) ? KIND_ACCEPT : KIND_REJECT;
      out_index <= timer_index;
      out_tag   <= '0;
      out_last  <= 1'b1;
    end else if (cmd.emit) begin
      if (sts.fire_now) begin
        out_kind  <= KIND_FIRED;
        out_index <= IDX_W'(w);
        out_tag   <= stored_tag[w];
        out_last  <= !later_fire;
      end else begin
        out_kind  <= KIND_QUIET;
        out_index <= '0;
        out_tag   <= '0;
        out_last  <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/multi_timer_bank.sv =====
// Bank of NUM_TIMERS one-shot or periodic timers driven by command words.
// Start and stop commands (and rejected or unknown ones) give one result
// word. A tick adds tick_step to the wrapping 32-bit time in the cycle it
// is taken and then walks the timer entries one per cycle, holding the
// command side until the walk ends; an entry that must give a result word
// waits while the consumer has not yet taken the previous one. A tick gives
// one word per timer that fires, in index order with last on the final one,
// or a single "tick without firing" word. A timer that crosses its deadline
// on a tick becomes pending and fires on the following tick. The result
// register frees itself as it is taken, so a new command word is taken in
// the same cycle the previous result leaves. Write tick_step only while the
// block is idle.
module multi_timer_bank (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [mtb_pkg::STEP_W-1:0] cfg_data,
  mtb_cmd_if.sink                    cmd,
  mtb_res_if.source                  res
);
  import mtb_pkg::*;

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;
  logic      in_is_tick;

  // ticks go to the walk; everything else gives its result word directly
  assign in_is_tick = (cmd.command == CMD_TICK);

  // sequencer: accept words, run the tick walk, hold on a busy result slot
  mtb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_is_tick (in_is_tick),
    .in_ready   (cmd.ready),
    .sts        (sts),
    .cmd        (ctl)
  );

  // timer state, running time and the result register
  mtb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .command     (cmd.command),
    .timer_index (cmd.timer_index),
    .periodic    (cmd.periodic),
    .delay       (cmd.delay),
    .user_tag    (cmd.user_tag),
    .cmd         (ctl),
    .sts         (sts),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_kind    (res.kind),
    .out_index   (res.fired_index),
    .out_tag     (res.fired_tag),
    .out_last    (res.last)
  );

endmodule

// ===== bench/tb_multi_timer_bank.sv =====
module tb_multi_timer_bank;
  timeunit 1ns;
  timeprecision 1ps;

  import mtb_pkg::*;

  // The block has no name for the fourth command code; it must be rejected.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] index;
    logic [31:0]      tag;
    logic             last;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [STEP_W-1:0] cfg_data;

  mtb_cmd_if cmd_if ();
  mtb_res_if res_if ();

  multi_timer_bank u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .res       (res_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the timer bank, kept in step with every accepted command word.
  logic [STEP_W-1:0] model_step;
  logic [TIME_W-1:0] model_now;
  status_t           model_status   [NUM_TIMERS];
  logic              model_mode     [NUM_TIMERS];
  logic [TIME_W-1:0] model_deadline [NUM_TIMERS];
  logic [TIME_W-1:0] model_period   [NUM_TIMERS];
  logic [31:0]       model_tag      [NUM_TIMERS];

  // Result words still owed by the block, oldest first.
  timer_result_t awaited_results [$];
  timer_result_t oldest;

  int mismatch_count = 0;
  bit send_idle      = 1'b1;
  bit recv_idle      = 1'b1;
  int recv_hold      = 0;

  function automatic void push_result(logic [1:0] kind, logic [IDX_W-1:0] idx);
    timer_result_t r;
    r.kind  = kind;
    r.index = idx;
    r.tag   = '0;
    r.last  = 1'b1;
    awaited_results.push_back(r);
  endfunction

  // Apply one command word to the shadow bank and queue the words it must produce.
  function automatic void advance_timer_bank(logic [1:0] command, logic [IDX_W-1:0] idx,
                                             logic periodic, logic [TIME_W-1:0] delay,
                                             logic [31:0] tag);
    timer_result_t held;
    int            fired;
    held  = '0;
    fired = 0;
    case (command)
      CMD_START: begin
        if (int'(idx) >= NUM_TIMERS || delay == '0) begin
          push_result(KIND_REJECT, idx);
        end else begin
          // Re-arm fully, even if the timer is already running or pending.
          model_deadline[idx] = model_now + delay;
          model_period[idx]   = delay;
          model_tag[idx]      = tag;
          model_mode[idx]     = periodic;
          model_status[idx]   = ST_RUNNING;
          push_result(KIND_ACCEPT, idx);
        end
      end
      CMD_STOP: begin
        if (int'(idx) >= NUM_TIMERS) begin
          push_result(KIND_REJECT, idx);
        end else begin
          model_status[idx] = ST_STOPPED;
          push_result(KIND_ACCEPT, idx);
        end
      end
      CMD_TICK: begin
        model_now = model_now + TIME_W'(model_step);
        // Walk in index order: a timer that crossed its deadline on an earlier
        // tick fires now, one that crosses it on this tick only turns pending.
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (model_status[i] == ST_RUNNING) begin
            if (model_deadline[i] < model_now) model_status[i] = ST_PENDING;
          end else if (model_status[i] == ST_PENDING) begin
            if (model_mode[i]) begin
              model_deadline[i] = model_now + model_period[i];
              model_status[i]   = ST_RUNNING;
            end else begin
              model_status[i] = ST_STOPPED;
            end
            // Hold back each fired word until we know whether it is the last one.
            if (fired != 0) awaited_results.push_back(held);
            held.kind  = KIND_FIRED;
            held.index = IDX_W'(i);
            held.tag   = model_tag[i];
            held.last  = 1'b0;
            fired++;
          end
        end
        if (fired == 0) begin
          push_result(KIND_QUIET, '0);
        end else begin
          held.last = 1'b1;
          awaited_results.push_back(held);
        end
      end
      default: push_result(KIND_REJECT, idx);
    endcase
  endfunction

  // Offer one command word, after a random gap while send_idle is set, and hold it until it is taken.
  task automatic send_word(input logic [1:0] command, input logic [IDX_W-1:0] idx,
                           input logic periodic, input logic [TIME_W-1:0] delay,
                           input logic [31:0] tag);
    int gap;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    // Drop valid only when a gap follows, so back-to-back words keep it high.
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= command;
    cmd_if.timer_index <= idx;
    cmd_if.periodic    <= periodic;
    cmd_if.delay       <= delay;
    cmd_if.user_tag    <= tag;
    do @(posedge clk); while (!cmd_if.ready);
    advance_timer_bank(command, idx, periodic, delay, tag);
  endtask

  // Mostly well-formed traffic: starts with delays a few ticks long so timers
  // actually fire, stops, and plenty of ticks; a little noise on top.
  task automatic send_random_word();
    int                pick;
    int                dsel;
    logic [1:0]        command;
    logic [TIME_W-1:0] delay;
    pick  = $urandom_range(0, 99);
    dsel  = $urandom_range(0, 9);
    delay = $urandom;
    if (pick < 30) begin
      command = CMD_START;
      if (dsel == 0) delay = '0;
      else if (dsel > 1) delay = $urandom_range(1, int'(model_step) * 6);
    end else if (pick < 40) begin
      command = CMD_STOP;
    end else if (pick < 45) begin
      command = CMD_UNKNOWN;
    end else begin
      command = CMD_TICK;
    end
    send_word(command, IDX_W'($urandom_range(0, NUM_TIMERS - 1)),
              1'($urandom_range(0, 1)), delay, $urandom);
  endtask

  // Drop valid, then wait until every owed word has come back and the block settles.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the step register once the block is idle.
  task automatic write_tick_step(input logic [STEP_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write  <= 1'b0;
    model_step  = value;
    @(posedge clk);
  endtask

  task automatic test_quiet_tick();
    // Nothing armed after reset: a tick gives one quiet word.
    send_word(CMD_TICK, 2'd0, 1'b0, '0, '0);
  endtask

  task automatic test_rejects();
    send_word(CMD_START, 2'd1, 1'b1, '0, 32'hFFFF_FFFF);
    send_word(CMD_UNKNOWN, 2'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Stopping a timer that never ran is still accepted.
    send_word(CMD_STOP, 2'd3, 1'b0, '0, '0);
  endtask

  task automatic test_one_shot();
    // Shortest delay: pending on the next tick, fires on the one after, then gone.
    send_word(CMD_START, 2'd0, 1'b0, 32'd1, 32'hFFFF_FFFF);
    repeat (3) send_word(CMD_TICK, 2'd0, 1'b0, '0, '0);
  endtask

  task automatic test_periodic_rearm();
    send_word(CMD_START, 2'd2, 1'b1, 32'd150, 32'h0000_0000);
    send_word(CMD_START, 2'd3, 1'b1, 32'd40, 32'hA5A5_A5A5);
    // Re-arm timer 3 as one-shot while it is running.
    send_word(CMD_START, 2'd3, 1'b0, 32'd50, 32'h5A5A_5A5A);
    // Largest delay wraps the deadline just below the current time.
    send_word(CMD_START, 2'd1, 1'b0, 32'hFFFF_FFFF, 32'h1234_5678);
    repeat (4) send_word(CMD_TICK, 2'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_STOP, 2'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (2) send_word(CMD_TICK, 2'd0, 1'b0, '0, '0);
  endtask

  task automatic test_time_wrap();
    // Largest step; a periodic timer whose deadline and reload wrap just below
    // the current time, so it keeps firing every other tick.
    write_tick_step(16'hFFFF);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_word(CMD_START, 2'd0, 1'b1, 32'hFFFF_FFFF, 32'hC0DE_0000);
    send_word(CMD_START, 2'd1, 1'b0, 32'h0002_0000, 32'hC0DE_0001);
    repeat (6) send_word(CMD_TICK, IDX_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         $urandom, $urandom);
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle);
    send_idle = with_idle;
    recv_idle = with_idle;
    repeat (count) send_random_word();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    // Keep offering words back to back while the consumer holds off, so the
    // result register fills and the command side has to stall.
    wait_idle();
    send_idle = 1'b0;
    recv_hold = 150;
    repeat (24) send_random_word();
    send_idle = 1'b1;
  endtask

  // Consumer side: random hold-off before each result word while recv_idle is set, or a long one on request.
  initial begin
    int gap;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, 11) : 0;
      if (recv_hold != 0) begin
        gap       = recv_hold;
        recv_hold = 0;
      end
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (mismatch_count < 10)
        $display("result mismatch on %s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result word taken with the oldest one still owed.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result word: kind %0d index %0d tag %h last %0d",
                   res_if.kind, res_if.fired_index, res_if.fired_tag, res_if.last);
        mismatch_count++;
      end else begin
        oldest = awaited_results.pop_front();
        check_field("kind", 32'(oldest.kind), 32'(res_if.kind));
        check_field("fired_index", 32'(oldest.index), 32'(res_if.fired_index));
        check_field("fired_tag", oldest.tag, res_if.fired_tag);
        check_field("last", 32'(oldest.last), 32'(res_if.last));
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_data           <= STEP_RESET;
    cmd_if.valid       <= 1'b0;
    cmd_if.command     <= CMD_TICK;
    cmd_if.timer_index <= '0;
    cmd_if.periodic    <= 1'b0;
    cmd_if.delay       <= '0;
    cmd_if.user_tag    <= '0;
    model_step = STEP_RESET;
    model_now  = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      model_status[i]   = ST_STOPPED;
      model_mode[i]     = 1'b0;
      model_deadline[i] = '0;
      model_period[i]   = '0;
      model_tag[i]      = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_quiet_tick();
    test_rejects();
    test_one_shot();
    test_periodic_rearm();
    test_time_wrap();

    // Random phases over several step settings, the extremes among them.
    write_tick_step(16'd1);
    test_random_traffic(75, 1'b1);
    write_tick_step(16'hFFFF);
    test_random_traffic(75, 1'b1);
    write_tick_step(STEP_RESET);
    test_random_traffic(75, 1'b0);
    test_backpressure();
    write_tick_step(STEP_W'($urandom_range(2, 65534)));
    test_random_traffic(75, 1'b1);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
